/* hdl/mbp_pkg.sv */
package mbp_pkg;

  localparam int unsigned BYTE_BITS    = 8;
  localparam int unsigned MAX_BYTES    = 4;
  localparam int unsigned VALUE_BITS   = 32;
  localparam int unsigned WORD_BITS    = VALUE_BITS + BYTE_BITS;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    OP_WRITE       = 3'd0,
    OP_ALIGN_ONES  = 3'd1,
    OP_ALIGN_ZEROS = 3'd2,
    OP_STOP_BIT    = 3'd3,
    OP_CLEAR       = 3'd4
  } op_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_BITS-1:0] bytes;
    logic [2:0]                          nbytes;
  } chunk_t;

endpackage

/* hdl/msb_first_bit_packer_top.sv */
// MSB-first bit packer. Each accepted item writes 0 to 32 bits of value, pads
// to a byte boundary with ones or zeros, writes a stop bit and pads with
// zeros, or clears the held bits. The resulting 0 to 4 complete bytes leave
// one per cycle on the byte channel while out_stall is low, in stream order,
// with last set on the final byte of each item. An item's bytes are queued
// in a two-entry queue, so input is accepted every cycle until that queue
// fills; the sustained rate is set by the byte output, one byte per cycle
// when not stalled, that is up to four bytes per item for a 32-bit write.
module msb_first_bit_packer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [31:0] value,
  input  logic [5:0]  bit_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last
);

  logic            accept;
  logic            push;
  logic            pop;
  logic            full;
  logic            not_empty;
  mbp_pkg::chunk_t wr_chunk;
  mbp_pkg::chunk_t rd_chunk;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  mbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .value     (value),
    .bit_count (bit_count),
    .push      (push),
    .chunk     (wr_chunk)
  );

  mbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_chunk  (wr_chunk),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .rd_chunk  (rd_chunk)
  );

  mbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .chunk     (rd_chunk),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

/* hdl/mbp_front.sv */
module mbp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [2:0]           operation,
  input  logic [31:0]          value,
  input  logic [5:0]           bit_count,
  output logic                 push,
  output mbp_pkg::chunk_t      chunk
);

  logic [7:0]  partial_bits;
  logic [2:0]  held_count;
  logic [7:0]  partial_bits_next;
  logic [2:0]  held_count_next;

  logic [2:0]  pad;
  logic [5:0]  n;
  logic [31:0] v;
  logic [31:0] v_masked;
  logic        clear;
  logic [5:0]  total;
  logic [5:0]  shift;
  logic [39:0] word;

  // Each operation is turned into a plain write of n bits of v.
  always_comb begin
    pad   = 3'(3'd0 - held_count);
    n     = '0;
    v     = '0;
    clear = 1'b0;
    case (operation)
      mbp_pkg::OP_WRITE: begin
        n = (bit_count > 6'd32) ? 6'd32 : bit_count;
        v = value;
      end
      mbp_pkg::OP_ALIGN_ONES: begin
        n = {3'b000, pad};
        v = '1;
      end
      mbp_pkg::OP_ALIGN_ZEROS: begin
        n = {3'b000, pad};
        v = '0;
      end
      mbp_pkg::OP_STOP_BIT: begin
        n = 6'd8 - {3'b000, held_count};
        v = 32'd1 << (3'd7 - held_count);
      end
      mbp_pkg::OP_CLEAR: begin
        clear = 1'b1;
      end
      default: begin
        n = '0;
      end
    endcase
  end

  always_comb begin
    v_masked = v & ~({32{1'b1}} << n);
    total    = {3'b000, held_count} + n;
    shift    = 6'd40 - total;
    word     = ({8'd0, v_masked} << shift) | {partial_bits, 32'd0};
    for (int j = 0; j < mbp_pkg::MAX_BYTES; j++) begin
      chunk.bytes[j] = word[39 - 8*j -: 8];
    end
    chunk.nbytes = total[5:3];
    case (total[5:3])
      3'd0:    partial_bits_next = word[39:32];
      3'd1:    partial_bits_next = word[31:24];
      3'd2:    partial_bits_next = word[23:16];
      3'd3:    partial_bits_next = word[15:8];
      default: partial_bits_next = word[7:0];
    endcase
    held_count_next = total[2:0];
    if (clear) begin
      partial_bits_next = '0;
      held_count_next   = '0;
    end
    push = accept && (total[5:3] != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_bits <= '0;
      held_count   <= '0;
    end else if (accept) begin
      partial_bits <= partial_bits_next;
      held_count   <= held_count_next;
    end
  end

endmodule

/* hdl/mbp_queue.sv */
module mbp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mbp_pkg::chunk_t wr_chunk,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output mbp_pkg::chunk_t rd_chunk
);

  mbp_pkg::chunk_t                  slots [mbp_pkg::QUEUE_DEPTH];
  logic [mbp_pkg::QUEUE_AW-1:0]     wr_ptr;
  logic [mbp_pkg::QUEUE_AW-1:0]     rd_ptr;
  logic [mbp_pkg::QUEUE_AW:0]       fill;

  assign full      = (fill == (mbp_pkg::QUEUE_AW+1)'(mbp_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign rd_chunk  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_chunk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* hdl/mbp_back.sv */
module mbp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            not_empty,
  input  mbp_pkg::chunk_t chunk,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            last
);

  logic [1:0] idx;
  logic       transfer;

  assign out_valid = not_empty;
  assign out_byte  = chunk.bytes[idx];
  assign last      = ({1'b0, idx} + 3'd1 == chunk.nbytes);
  assign transfer  = out_valid && !out_stall;
  assign pop       = transfer && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (transfer) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule
